>>> hdl/dtmf_pkg.sv
// ----------------------------------------------------------------------------
// dtmf_pkg
// shared types, constants and the code-to-pattern table of the relay sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtmf_pkg;

    localparam int NUM_CH     = 2;
    localparam int CODE_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int DUR_W      = 16;
    localparam int STAMP_W    = 32;
    localparam int RELAY_W    = NUM_CH * BYTE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 72;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP   = 2'd2;

    localparam logic [7:0] HOLD_TICKS_RST  = 8'd15;
    localparam logic [7:0] GUARD_TICKS_RST = 8'd15;
    localparam logic [7:0] TICK_STEP_RST   = 8'd20;

    localparam logic [BYTE_W-1:0] STORE_BIT = 8'h20;
    localparam logic [DUR_W-1:0]  DUR_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [7:0] hold_ticks;
        logic [7:0] guard_ticks;
        logic [7:0] tick_step_ms;
    } cfg_t;

    typedef struct packed {
        logic               tick;
        logic               strobe;
        logic [CODE_W-1:0]  code;
        logic               level;
        logic [STAMP_W-1:0] tick_count;
    } lane_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  relay_byte;
        logic               busy;
        logic               fired;
        logic [CODE_W-1:0]  digit;
        logic [DUR_W-1:0]   duration;
        logic [STAMP_W-1:0] stamp;
    } lane_out_t;

    typedef struct packed {
        logic [STAMP_W-1:0] event_timestamp;
        logic [DUR_W-1:0]   event_duration_ms;
        logic [CODE_W-1:0]  event_digit;
        logic               event_channel;
        logic               event_valid;
        logic [NUM_CH-1:0]  chan_busy;
        logic [RELAY_W-1:0] relay_word;
    } result_t;

    function automatic logic [4:0] pattern_of_code(input logic [CODE_W-1:0] code);
        logic [4:0] pat;
        begin
            case (code)
                4'd1:    pat = 5'h03;
                4'd2:    pat = 5'h04;
                4'd3:    pat = 5'h0F;
                4'd4:    pat = 5'h0C;
                4'd5:    pat = 5'h0B;
                4'd6:    pat = 5'h10;
                4'd7:    pat = 5'h13;
                4'd8:    pat = 5'h14;
                4'd9:    pat = 5'h1F;
                4'd10:   pat = 5'h1C;
                default: pat = 5'h00;
            endcase
            return pat;
        end
    endfunction

endpackage

>>> hdl/dtmf_lane.sv
// ----------------------------------------------------------------------------
// dtmf_lane
// per-channel digit sequencer: latches strobes, steps the dial phases on ticks
// and drives its own byte of the relay word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtmf_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  dtmf_pkg::cfg_t      cfg,
    input  dtmf_pkg::lane_in_t  lin,
    output dtmf_pkg::lane_out_t lout
);

    typedef enum logic [2:0]
    {
        PH_IDLE    = 3'd0,
        PH_WAIT    = 3'd1,
        PH_OPERATE = 3'd2,
        PH_HOLD    = 3'd3,
        PH_RELEASE = 3'd4,
        PH_GUARD   = 3'd5
    } phase_t;

    phase_t                             phase_reg, phase_next;
    logic [dtmf_pkg::CODE_W-1:0]        code_reg, code_next;
    logic [7:0]                         delay_reg, delay_next;
    logic [dtmf_pkg::DUR_W-1:0]         dur_reg, dur_next;
    logic [dtmf_pkg::CODE_W-1:0]        digit_reg, digit_next;
    logic [dtmf_pkg::STAMP_W-1:0]       stamp_reg, stamp_next;
    logic [dtmf_pkg::BYTE_W-1:0]        relay_reg, relay_next;
    logic                               fired;
    logic [dtmf_pkg::DUR_W:0]           dur_sum;
    logic [4:0]                         pat;
    logic [7:0]                         delay_inc;

    assign dur_sum   = {1'b0, dur_reg} + {9'd0, cfg.tick_step_ms};
    assign pat       = dtmf_pkg::pattern_of_code(code_reg);
    assign delay_inc = delay_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        code_next  = code_reg;
        delay_next = delay_reg;
        dur_next   = dur_reg;
        digit_next = digit_reg;
        stamp_next = stamp_reg;
        relay_next = relay_reg;
        fired      = 1'b0;
        if (lin.strobe)
        begin
            code_next  = lin.code;
            stamp_next = lin.tick_count;
        end
        else if (lin.tick)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (code_reg != '0)
                    begin
                        phase_next = PH_WAIT;
                        digit_next = code_reg;
                        dur_next   = '0;
                    end
                end
                PH_WAIT:
                begin
                    dur_next = dur_sum[dtmf_pkg::DUR_W] ? dtmf_pkg::DUR_MAX
                                                        : dur_sum[dtmf_pkg::DUR_W-1:0];
                    if (!lin.level)
                        phase_next = PH_OPERATE;
                end
                PH_OPERATE:
                begin
                    code_next = '0;
                    if (pat != '0)
                        relay_next = {3'b000, pat} | dtmf_pkg::STORE_BIT;
                    phase_next = PH_HOLD;
                    fired      = 1'b1;
                end
                PH_HOLD:
                begin
                    delay_next = delay_inc;
                    if (delay_inc == cfg.hold_ticks)
                    begin
                        delay_next = '0;
                        phase_next = PH_RELEASE;
                    end
                end
                PH_RELEASE:
                begin
                    relay_next = '0;
                    phase_next = PH_GUARD;
                end
                PH_GUARD:
                begin
                    delay_next = delay_inc;
                    if (delay_inc == cfg.guard_ticks)
                    begin
                        delay_next = '0;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            code_reg  <= '0;
            delay_reg <= '0;
            dur_reg   <= '0;
            digit_reg <= '0;
            stamp_reg <= '0;
            relay_reg <= '0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            code_reg  <= code_next;
            delay_reg <= delay_next;
            dur_reg   <= dur_next;
            digit_reg <= digit_next;
            stamp_reg <= stamp_next;
            relay_reg <= relay_next;
        end
    end

    // record fields are untouched by the operate step, so current values serve
    assign lout.relay_byte = relay_next;
    assign lout.busy       = (phase_next != PH_IDLE);
    assign lout.fired      = fired;
    assign lout.digit      = digit_reg;
    assign lout.duration   = dur_reg;
    assign lout.stamp      = stamp_reg;

endmodule

>>> hdl/dtmf_merge.sv
// ----------------------------------------------------------------------------
// dtmf_merge
// combines the lane results into one record (channel 0 wins) and queues it in
// a two-entry output register with skid stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtmf_merge
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                push_ready,
    input  dtmf_pkg::lane_out_t lanes [dtmf_pkg::NUM_CH],
    output logic                out_valid,
    input  logic                out_ready,
    output dtmf_pkg::result_t   out_data
);

    dtmf_pkg::result_t  res;
    dtmf_pkg::result_t  head_reg, head_next;
    dtmf_pkg::result_t  skid_reg, skid_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               pop;
    logic               sel;

    always_comb
    begin
        sel = !lanes[0].fired;
        res = '0;
        res.relay_word = {lanes[1].relay_byte, lanes[0].relay_byte};
        res.chan_busy  = {lanes[1].busy, lanes[0].busy};
        if (lanes[0].fired || lanes[1].fired)
        begin
            res.event_valid       = 1'b1;
            res.event_channel     = sel;
            res.event_digit       = lanes[sel].digit;
            res.event_duration_ms = lanes[sel].duration;
            res.event_timestamp   = lanes[sel].stamp;
        end
    end

    assign push_ready = (cnt_reg != 2'd2);
    assign out_valid  = (cnt_reg != 2'd0);
    assign out_data   = head_reg;
    assign pop        = out_valid && out_ready;

    always_comb
    begin
        head_next = head_reg;
        skid_next = skid_reg;
        cnt_next  = cnt_reg;
        case ({push, pop})
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                    head_next = res;
                else
                begin
                    head_next = skid_reg;
                    skid_next = res;
                end
            end
            2'b01:
            begin
                head_next = skid_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    head_next = res;
                else
                    skid_next = res;
                cnt_next = cnt_reg + 2'd1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

>>> hdl/dtmf_digit_relay_sequencer_top.sv
// ----------------------------------------------------------------------------
// dtmf_digit_relay_sequencer_top
// two-channel dtmf digit to relay pattern sequencer
//
// s_axis carries one request per transfer: s_tuser is the kind (0 tick,
// 1 strobe), s_tdata the strobe channel, tone code and strobe levels.
// m_axis returns exactly one result per request: relay word, busy bits and,
// when m_tuser is high, the record of a digit that finished on that tick.
// cfg_we/cfg_index/cfg_data write hold_ticks (0), guard_ticks (1) and
// tick_step_ms (2); write only while no result is outstanding.
// each channel has its own sequencer lane; a merge stage picks the event
// (channel 0 first) and builds the result word.
// the result is registered in the output queue and read out on m_axis.
// the lanes update on each transfer; one request per cycle while s_tready is high.
// a two-entry output queue lets s_tready stay high while one result waits;
// s_tready drops only when two results are held by a stalled receiver.
// reset clears the tick counter, all lane state, relays and the queue, and
// loads the register defaults 15, 15 and 20.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtmf_digit_relay_sequencer_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dtmf_pkg::S_DATA_W-1:0]       s_tdata,  // strobe_channel, tone_code[3:0], strobe_levels[1:0], pad
    input  logic                                s_tuser,  // req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dtmf_pkg::M_DATA_W-1:0]       m_tdata,  // relay_word[15:0], chan_busy[1:0], event_channel, event_digit[3:0], event_duration_ms[15:0], event_timestamp[31:0], pad
    output logic                                m_tuser,  // event_valid
    input  logic                                cfg_we,
    input  logic [dtmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dtmf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dtmf_pkg::cfg_t                 cfg_reg;
    logic [dtmf_pkg::STAMP_W-1:0]   tick_count_reg, tick_count_next;
    logic                           accept;
    logic                           is_tick;
    logic                           strobe_channel;
    logic [dtmf_pkg::CODE_W-1:0]    tone_code;
    logic [dtmf_pkg::NUM_CH-1:0]    strobe_levels;
    dtmf_pkg::lane_in_t             lane_in  [dtmf_pkg::NUM_CH];
    dtmf_pkg::lane_out_t            lane_out [dtmf_pkg::NUM_CH];
    dtmf_pkg::result_t              res;

    assign accept         = s_tvalid && s_tready;
    assign is_tick        = !s_tuser;
    assign strobe_channel = s_tdata[0];
    assign tone_code      = s_tdata[4:1];
    assign strobe_levels  = s_tdata[6:5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks   <= dtmf_pkg::HOLD_TICKS_RST;
            cfg_reg.guard_ticks  <= dtmf_pkg::GUARD_TICKS_RST;
            cfg_reg.tick_step_ms <= dtmf_pkg::TICK_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dtmf_pkg::CFG_HOLD_TICKS:  cfg_reg.hold_ticks   <= cfg_data;
                dtmf_pkg::CFG_GUARD_TICKS: cfg_reg.guard_ticks  <= cfg_data;
                dtmf_pkg::CFG_TICK_STEP:   cfg_reg.tick_step_ms <= cfg_data;
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign tick_count_next = tick_count_reg + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_count_reg <= '0;
        else if (accept && is_tick)
            tick_count_reg <= tick_count_next;
    end

    for (genvar i = 0; i < dtmf_pkg::NUM_CH; i++)
    begin : g_lane
        assign lane_in[i].tick       = is_tick;
        assign lane_in[i].strobe     = s_tuser && (strobe_channel == i[0]);
        assign lane_in[i].code       = tone_code;
        assign lane_in[i].level      = strobe_levels[i];
        assign lane_in[i].tick_count = tick_count_reg;

        dtmf_lane u_lane
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (accept),
            .cfg   (cfg_reg),
            .lin   (lane_in[i]),
            .lout  (lane_out[i])
        );
    end

    dtmf_merge u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_ready (s_tready),
        .lanes      (lane_out),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (res)
    );

    assign m_tuser = res.event_valid;
    assign m_tdata = {1'b0, res.event_timestamp, res.event_duration_ms, res.event_digit,
                      res.event_channel, res.chan_busy, res.relay_word};

    // a finished digit leaves its channel in hold, so it reads busy
    a_event_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[18] ? m_tdata[17] : m_tdata[16]))
        else $error("event reported for an idle channel");

    // without an event every record field reads zero
    a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[70:18] == '0))
        else $error("record fields set without event");

    // an operated channel 0 relay byte carries the store bit and channel 0 reads busy
    a_relay_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[7:0] != 8'd0)) |-> (m_tdata[5] && m_tdata[16]))
        else $error("channel 0 relays driven while idle");

    // the tick counter moves only on a tick transfer
    a_tick_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && is_tick) |=> $stable(tick_count_reg))
        else $error("tick counter moved without a tick");

endmodule

>>> tb/dtmf_digit_relay_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// dtmf_digit_relay_sequencer_top_tb
// self-checking bench for the two-channel dtmf relay sequencer
//
// a queue of tick and strobe requests feeds the slave stream. every accepted
// transfer also runs through a lane-by-lane software copy of the sequencer,
// and the result it predicts is queued. the monitor checks each master
// transfer field by field against the oldest prediction. the run starts
// with a short directed sequence. random phases follow, each with its own
// hold, guard and step settings (extremes and the wrapping zero counts
// included) and its own mix of sender gaps and receiver stalls. one phase
// holds the receiver off long enough to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtmf_digit_relay_sequencer_top_tb;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLDOFF_LEN = 400;

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_STROBE = 1'b1;

    // 5-bit relay pattern per tone code, code 0 in the lowest bits
    localparam logic [16*5-1:0] PATTERN_ROM = {
        5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1C, 5'h1F, 5'h14,
        5'h13, 5'h10, 5'h0B, 5'h0C, 5'h0F, 5'h04, 5'h03, 5'h00
    };

    typedef enum logic [2:0]
    {
        PH_IDLE,
        PH_WAIT,
        PH_OPERATE,
        PH_HOLD,
        PH_RELEASE,
        PH_GUARD
    } dial_phase_t;

    typedef struct packed {
        logic                        kind;
        logic                        channel;
        logic [dtmf_pkg::CODE_W-1:0] code;
        logic [dtmf_pkg::NUM_CH-1:0] levels;
    } tone_req_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [dtmf_pkg::S_DATA_W-1:0]   s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [dtmf_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            m_tuser;
    logic                            cfg_we    = 1'b0;
    logic [dtmf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dtmf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    tone_req_t           tone_req_q[$];
    dtmf_pkg::result_t   relay_result_q[$];
    tone_req_t           offered_req;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic pressure_on    = 1'b0;
    logic hold_off       = 1'b0;
    int   mismatch_cnt   = 0;
    int   cycle_cnt      = 0;

    // sequencer copy
    logic [7:0]                   hold_lim   = dtmf_pkg::HOLD_TICKS_RST;
    logic [7:0]                   guard_lim  = dtmf_pkg::GUARD_TICKS_RST;
    logic [7:0]                   step_ms    = dtmf_pkg::TICK_STEP_RST;
    logic [dtmf_pkg::STAMP_W-1:0] tick_cnt   = '0;
    logic [dtmf_pkg::RELAY_W-1:0] relay_bits = '0;
    dial_phase_t                  lane_phase [dtmf_pkg::NUM_CH] = '{PH_IDLE, PH_IDLE};
    logic [dtmf_pkg::CODE_W-1:0]  lane_code  [dtmf_pkg::NUM_CH] = '{4'd0, 4'd0};
    logic [dtmf_pkg::CODE_W-1:0]  lane_digit [dtmf_pkg::NUM_CH] = '{4'd0, 4'd0};
    logic [7:0]                   lane_delay [dtmf_pkg::NUM_CH] = '{8'd0, 8'd0};
    logic [dtmf_pkg::DUR_W-1:0]   lane_dur   [dtmf_pkg::NUM_CH] = '{16'd0, 16'd0};
    logic [dtmf_pkg::STAMP_W-1:0] lane_stamp [dtmf_pkg::NUM_CH] = '{32'd0, 32'd0};

    dtmf_digit_relay_sequencer_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic step_lane(input int ch, input logic level);
        logic [dtmf_pkg::DUR_W:0] sum;
        logic [4:0]               pat;
        logic                     fired;
        fired = 1'b0;
        case (lane_phase[ch])
            PH_IDLE:
            begin
                if (lane_code[ch] != '0)
                begin
                    lane_phase[ch] = PH_WAIT;
                    lane_digit[ch] = lane_code[ch];
                    lane_dur[ch]   = '0;
                end
            end
            PH_WAIT:
            begin
                sum = {1'b0, lane_dur[ch]} + {9'd0, step_ms};
                lane_dur[ch] = sum[dtmf_pkg::DUR_W] ? dtmf_pkg::DUR_MAX
                                                    : sum[dtmf_pkg::DUR_W-1:0];
                if (!level)
                    lane_phase[ch] = PH_OPERATE;
            end
            PH_OPERATE:
            begin
                pat = PATTERN_ROM[lane_code[ch]*5 +: 5];
                lane_code[ch] = '0;
                if (pat != '0)
                    relay_bits[ch*dtmf_pkg::BYTE_W +: dtmf_pkg::BYTE_W] =
                        {3'b000, pat} | dtmf_pkg::STORE_BIT;
                lane_phase[ch] = PH_HOLD;
                fired = 1'b1;
            end
            PH_HOLD:
            begin
                lane_delay[ch] = lane_delay[ch] + 8'd1;
                if (lane_delay[ch] == hold_lim)
                begin
                    lane_delay[ch] = '0;
                    lane_phase[ch] = PH_RELEASE;
                end
            end
            PH_RELEASE:
            begin
                relay_bits[ch*dtmf_pkg::BYTE_W +: dtmf_pkg::BYTE_W] = '0;
                lane_phase[ch] = PH_GUARD;
            end
            PH_GUARD:
            begin
                lane_delay[ch] = lane_delay[ch] + 8'd1;
                if (lane_delay[ch] == guard_lim)
                begin
                    lane_delay[ch] = '0;
                    lane_phase[ch] = PH_IDLE;
                end
            end
            default:
            begin
                lane_phase[ch] = PH_IDLE;
            end
        endcase
        return fired;
    endfunction

    function automatic dtmf_pkg::result_t predict_result(input tone_req_t req);
        dtmf_pkg::result_t res;
        int                ch;
        res = '0;
        if (req.kind == REQ_STROBE)
        begin
            lane_code[req.channel]  = req.code;
            lane_stamp[req.channel] = tick_cnt;
        end
        else
        begin
            tick_cnt = tick_cnt + 32'd1;
            for (ch = 0; ch < dtmf_pkg::NUM_CH; ch++)
            begin
                // channel 0 wins when both fire on one tick
                if (step_lane(ch, req.levels[ch]) && !res.event_valid)
                begin
                    res.event_valid       = 1'b1;
                    res.event_channel     = ch[0];
                    res.event_digit       = lane_digit[ch];
                    res.event_duration_ms = lane_dur[ch];
                    res.event_timestamp   = lane_stamp[ch];
                end
            end
        end
        res.relay_word   = relay_bits;
        res.chan_busy[0] = (lane_phase[0] != PH_IDLE);
        res.chan_busy[1] = (lane_phase[1] != PH_IDLE);
        return res;
    endfunction

    // driver: one offered request at a time, prediction on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                relay_result_q.push_back(predict_result(offered_req));
            if (!s_tvalid || s_tready)
            begin
                if (tone_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_req = tone_req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= offered_req.kind;
                    s_tdata  <= {1'b0, offered_req.levels, offered_req.code,
                                 offered_req.channel};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_cnt++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // monitor: random stalls, long hold-off, field compare per transfer
    always @(posedge clk or negedge rst_n)
    begin
        dtmf_pkg::result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready)
            begin
                if (relay_result_q.size() == 0)
                begin
                    mismatch_cnt++;
                    $display("%0t: unexpected transfer expected none actual %h/%b",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = relay_result_q.pop_front();
                    check_field("relay_word", 32'(want.relay_word), 32'(m_tdata[15:0]));
                    check_field("chan_busy", 32'(want.chan_busy), 32'(m_tdata[17:16]));
                    check_field("event_valid", 32'(want.event_valid), 32'(m_tuser));
                    check_field("event_channel", 32'(want.event_channel),
                                32'(m_tdata[18]));
                    check_field("event_digit", 32'(want.event_digit),
                                32'(m_tdata[22:19]));
                    check_field("event_duration_ms", 32'(want.event_duration_ms),
                                32'(m_tdata[38:23]));
                    check_field("event_timestamp", want.event_timestamp,
                                m_tdata[70:39]);
                end
            end
        end
    end

    // long receiver hold-off so the output queue fills and s_tready drops
    initial
    begin
        wait (pressure_on);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLDOFF_LEN) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("dtmf_digit_relay_sequencer_top_tb: errors");
            $finish;
        end
    end

    task automatic queue_req(input logic kind, input logic channel,
                             input logic [dtmf_pkg::CODE_W-1:0] code,
                             input logic [dtmf_pkg::NUM_CH-1:0] levels);
        tone_req_t req;
        req.kind    = kind;
        req.channel = channel;
        req.code    = code;
        req.levels  = levels;
        tone_req_q.push_back(req);
    endtask

    // strobes start tones of random length; the tone's level stays high on
    // following ticks, with some noise on the levels
    task automatic queue_random_traffic(input int count);
        int                          tone_left [dtmf_pkg::NUM_CH];
        int                          n;
        int                          ch;
        logic [dtmf_pkg::CODE_W-1:0] code;
        logic [dtmf_pkg::NUM_CH-1:0] lv;
        tone_left = '{0, 0};
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 14)
            begin
                ch   = $urandom_range(1);
                code = ($urandom_range(99) < 80) ? 4'($urandom_range(10, 1))
                                                 : 4'($urandom_range(15));
                queue_req(REQ_STROBE, ch[0], code, 2'($urandom_range(3)));
                tone_left[ch] = $urandom_range(6);
            end
            else
            begin
                lv = {tone_left[1] > 0, tone_left[0] > 0};
                if ($urandom_range(99) < 5)
                    lv = 2'($urandom_range(3));
                queue_req(REQ_TICK, 1'($urandom_range(1)), 4'($urandom_range(15)), lv);
                for (ch = 0; ch < dtmf_pkg::NUM_CH; ch++)
                    if (tone_left[ch] > 0)
                        tone_left[ch]--;
            end
        end
    endtask

    task automatic wait_idle();
        while (tone_req_q.size() != 0 || s_tvalid || relay_result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [dtmf_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            dtmf_pkg::CFG_HOLD_TICKS:  hold_lim  = value;
            dtmf_pkg::CFG_GUARD_TICKS: guard_lim = value;
            dtmf_pkg::CFG_TICK_STEP:   step_ms   = value;
            default:                   ;
        endcase
    endtask

    task automatic start_phase(input logic [7:0] hold, input logic [7:0] guard,
                               input logic [7:0] step, input int idle_pct, input int stall_pct);
        wait_idle();
        write_register(dtmf_pkg::CFG_HOLD_TICKS, hold);
        write_register(dtmf_pkg::CFG_GUARD_TICKS, guard);
        write_register(dtmf_pkg::CFG_TICK_STEP, step);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    initial
    begin
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: both lanes through operate on the same tick
        queue_req(REQ_TICK, 1'b0, 4'd0, 2'b00);
        queue_req(REQ_STROBE, 1'b0, 4'd9, 2'b11);
        queue_req(REQ_STROBE, 1'b1, 4'd10, 2'b00);
        queue_req(REQ_TICK, 1'b1, 4'd15, 2'b11);
        queue_req(REQ_TICK, 1'b0, 4'd0, 2'b11);
        queue_req(REQ_STROBE, 1'b1, 4'd3, 2'b01);
        queue_req(REQ_TICK, 1'b0, 4'd0, 2'b00);
        queue_req(REQ_TICK, 1'b1, 4'd5, 2'b00);
        queue_req(REQ_TICK, 1'b0, 4'd0, 2'b10);
        // codes latched after operate, one with no pattern, one empty
        queue_req(REQ_STROBE, 1'b0, 4'd15, 2'b10);
        queue_req(REQ_STROBE, 1'b1, 4'd11, 2'b11);
        queue_req(REQ_STROBE, 1'b1, 4'd0, 2'b00);
        queue_req(REQ_TICK, 1'b1, 4'd0, 2'b11);
        queue_req(REQ_STROBE, 1'b0, 4'd6, 2'b00);
        queue_req(REQ_TICK, 1'b0, 4'd0, 2'b01);

        // long tone at the largest step: duration saturates
        start_phase(8'd1, 8'd1, 8'd255, 0, 0);
        queue_req(REQ_STROBE, 1'b1, 4'd7, 2'b00);
        for (n = 0; n < 262; n++)
            queue_req(REQ_TICK, 1'b0, 4'd0, 2'b10);
        for (n = 0; n < 5; n++)
            queue_req(REQ_TICK, 1'b0, 4'd0, 2'b00);
        queue_random_traffic(300);

        start_phase(8'd3, 8'd2, 8'd1, 86, 0);
        queue_random_traffic(300);

        start_phase(8'd2, 8'd5, 8'd137, 0, 86);
        queue_random_traffic(300);

        start_phase(8'd4, 8'd3, 8'd20, 6, 6);
        queue_random_traffic(300);
        pressure_on = 1'b1;

        start_phase(8'd255, 8'd255, 8'd128, 0, 0);
        queue_random_traffic(250);

        // zero counts wrap to 256 ticks
        start_phase(8'd0, 8'd0, 8'd255, 6, 6);
        queue_random_traffic(300);

        wait_idle();
        repeat (16) @(posedge clk);
        if (mismatch_cnt == 0 && relay_result_q.size() == 0)
            $display("dtmf_digit_relay_sequencer_top_tb: clean");
        else
            $display("dtmf_digit_relay_sequencer_top_tb: errors");
        $finish;
    end

endmodule
